/* hdl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, step table and types of the quaternion to Euler
// angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_LAT        = CORDIC_ITERATIONS + 2;
  localparam int SQRT_BITS         = 29;
  localparam int SQRT_IN_W         = 2 * SQRT_BITS;
  localparam int SQRT_REM_W        = SQRT_BITS + 3;
  localparam int ARG_W             = 34;
  localparam int VEC_W             = 38;
  localparam int ACC_W             = 26;
  localparam int ANG_W             = 16;
  localparam int PITCH_W           = 15;

  localparam logic signed [ARG_W-1:0] ONE_Q28     = ARG_W'(268435456);
  localparam logic signed [ACC_W-1:0] PI_Q20      = ACC_W'(3294199);
  localparam logic signed [ANG_W-1:0] PI_Q13      = ANG_W'(25736);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = ANG_W'(12868);

  typedef struct packed {
    logic signed [ARG_W-1:0] roll_x;
    logic signed [ARG_W-1:0] roll_y;
    logic signed [ARG_W-1:0] yaw_x;
    logic signed [ARG_W-1:0] yaw_y;
    logic signed [ARG_W-1:0] s;
    logic                    sat_pos;
    logic                    sat_neg;
  } side_t;

  typedef struct packed {
    logic sat_pos;
    logic sat_neg;
  } sat_t;

  function automatic logic signed [ACC_W-1:0] atan_step(input int idx);
    logic signed [ACC_W-1:0] r;
    unique case (idx)
      0:  r = ACC_W'(823550);
      1:  r = ACC_W'(486170);
      2:  r = ACC_W'(256879);
      3:  r = ACC_W'(130396);
      4:  r = ACC_W'(65451);
      5:  r = ACC_W'(32757);
      6:  r = ACC_W'(16383);
      7:  r = ACC_W'(8192);
      8:  r = ACC_W'(4096);
      9:  r = ACC_W'(2048);
      10: r = ACC_W'(1024);
      11: r = ACC_W'(512);
      12: r = ACC_W'(256);
      13: r = ACC_W'(128);
      14: r = ACC_W'(64);
      15: r = ACC_W'(32);
      16: r = ACC_W'(16);
      17: r = ACC_W'(8);
      18: r = ACC_W'(4);
      19: r = ACC_W'(2);
      20: r = ACC_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/qte_sqrt.sv */
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [qte_pkg::SQRT_IN_W-1:0] rad_i,
  output logic [qte_pkg::SQRT_BITS-1:0] root_o
);
  import qte_pkg::*;

  logic [SQRT_REM_W-1:0] rem_q  [SQRT_BITS];
  logic [SQRT_BITS-1:0]  root_q [SQRT_BITS];
  logic [SQRT_IN_W-1:0]  v_q    [SQRT_BITS];

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
    logic [SQRT_REM_W-1:0] rem_in;
    logic [SQRT_BITS-1:0]  root_in;
    logic [SQRT_IN_W-1:0]  v_in;
    logic [SQRT_REM_W-1:0] rem_sh;
    logic [SQRT_REM_W-1:0] test;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign rem_sh = {rem_in[SQRT_REM_W-3:0], v_in[SQRT_IN_W-1 -: 2]};
    assign test   = SQRT_REM_W'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k] <= {v_in[SQRT_IN_W-3:0], 2'b00};
        if (rem_sh >= test) begin
          rem_q[k]  <= rem_sh - test;
          root_q[k] <= {root_in[SQRT_BITS-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[SQRT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQRT_BITS-1];

endmodule

/* hdl/qte_cordic.sv */
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2, one rotation per stage, Q3.13 result
// clamped to plus or minus pi.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [qte_pkg::ARG_W-1:0]   y_i,
  input  logic signed [qte_pkg::ARG_W-1:0]   x_i,
  output logic signed [qte_pkg::ANG_W-1:0]   angle_o
);
  import qte_pkg::*;

  logic signed [VEC_W-1:0] x_q    [CORDIC_ITERATIONS+1];
  logic signed [VEC_W-1:0] y_q    [CORDIC_ITERATIONS+1];
  logic signed [ACC_W-1:0] acc_q  [CORDIC_ITERATIONS+1];
  logic                    zero_q [CORDIC_ITERATIONS+1];
  logic signed [ANG_W-1:0] angle_q;

  logic signed [VEC_W-1:0]   x_ext, y_ext;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ACC_W-8:0]   ang_full;

  assign x_ext = VEC_W'(x_i);
  assign y_ext = VEC_W'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0]   <= -x_ext;
        y_q[0]   <= -y_ext;
        acc_q[0] <= (y_i >= 0) ? PI_Q20 : -PI_Q20;
      end else begin
        x_q[0]   <= x_ext;
        y_q[0]   <= y_ext;
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
    logic signed [VEC_W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1]   <= x_q[i] + dx;
          y_q[i+1]   <= y_q[i] - dy;
          acc_q[i+1] <= acc_q[i] + atan_step(i);
        end else begin
          x_q[i+1]   <= x_q[i] - dx;
          y_q[i+1]   <= y_q[i] + dy;
          acc_q[i+1] <= acc_q[i] - atan_step(i);
        end
      end
    end
  end

  assign acc_rnd  = acc_q[CORDIC_ITERATIONS] + ACC_W'(64);
  assign ang_full = acc_rnd[ACC_W-1:7];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      priority if (zero_q[CORDIC_ITERATIONS]) begin
        angle_q <= '0;
      end else if (ang_full > (ACC_W-7)'(PI_Q13)) begin
        angle_q <= PI_Q13;
      end else if (ang_full < -(ACC_W-7)'(PI_Q13)) begin
        angle_q <= -PI_Q13;
      end else begin
        angle_q <= ANG_W'(ang_full);
      end
    end
  end

  assign angle_o = angle_q;

endmodule

/* hdl/quaternion_to_euler.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Converts a unit quaternion in Q1.14 to ZYX Euler angles in Q3.13 radians.
// ----------------------------------------------------------------------------
// Input channel s_axis: one word per quaternion, w, x, y, z from the low
// bits up, 16 bits each, signed Q1.14.
// Output channel m_axis: one word per quaternion, roll (16 bits), pitch
// (15 bits) and yaw (16 bits) from the low bits up, zero padded to 48 bits;
// tuser carries the pitch saturation flag, set when |2(wy-zx)| >= 1 and
// pitch is held at plus or minus pi/2.
// The pipeline runs products, sums and squaring, then the square root for
// the pitch cosine (one root bit per stage), then CORDIC (16 rotations
// plus entry and rounding) and one output register. Throughput is one
// word per cycle while the receiver does not stall.
// The whole pipeline advances together; when the receiver stalls with a
// word waiting at the output, every stage holds and s_axis_tready drops.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, pad
  output logic        m_axis_tuser    // pitch_saturated
);
  import qte_pkg::*;

  localparam int SIDE_DLY = 2 + SQRT_BITS;
  localparam int PIPE_LEN = 4 + SQRT_BITS + CORDIC_LAT + 1;

  logic                en;
  logic [PIPE_LEN-1:0] valid_q;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, wy_q, zx_q, zz_q;

  side_t                     side_q [SIDE_DLY+1];
  side_t                     side_d;
  logic signed [ARG_W-1:0]   s_abs;
  logic [55:0]               sq_q;
  logic [SQRT_IN_W-1:0]      rad_q;
  logic [SQRT_BITS-1:0]      root;
  sat_t                      sat_q [CORDIC_LAT];
  logic signed [ANG_W-1:0]   roll_ang, yaw_ang, pitch_ang;
  logic signed [ANG_W-1:0]   roll_q, yaw_q;
  logic signed [PITCH_W-1:0] pitch_q;
  logic                      flag_q;
  side_t                     side_out;

  assign en            = !valid_q[PIPE_LEN-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_LEN-2:0], s_axis_tvalid};
    end
  end

  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= qw * qx;
      yz_q <= qy * qz;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      wz_q <= qw * qz;
      xy_q <= qx * qy;
      wy_q <= qw * qy;
      zx_q <= qz * qx;
    end
  end

  always_comb begin
    side_d.roll_y  = (ARG_W'(wx_q) + ARG_W'(yz_q)) <<< 1;
    side_d.roll_x  = ONE_Q28 - ((ARG_W'(xx_q) + ARG_W'(yy_q)) <<< 1);
    side_d.yaw_y   = (ARG_W'(wz_q) + ARG_W'(xy_q)) <<< 1;
    side_d.yaw_x   = ONE_Q28 - ((ARG_W'(yy_q) + ARG_W'(zz_q)) <<< 1);
    side_d.s       = (ARG_W'(wy_q) - ARG_W'(zx_q)) <<< 1;
    side_d.sat_pos = side_d.s >= ONE_Q28;
    side_d.sat_neg = side_d.s <= -ONE_Q28;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k <= SIDE_DLY; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign s_abs = side_q[0].s[ARG_W-1] ? -side_q[0].s : side_q[0].s;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q  <= s_abs[27:0] * s_abs[27:0];
      rad_q <= SQRT_IN_W'((57'(1) <<< 56) - 57'(sq_q));
    end
  end

  qte_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  assign side_out = side_q[SIDE_DLY];

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (side_out.roll_y),
    .x_i     (side_out.roll_x),
    .angle_o (roll_ang)
  );

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (side_out.yaw_y),
    .x_i     (side_out.yaw_x),
    .angle_o (yaw_ang)
  );

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (side_out.s),
    .x_i     (ARG_W'(root)),
    .angle_o (pitch_ang)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q[0].sat_pos <= side_out.sat_pos;
      sat_q[0].sat_neg <= side_out.sat_neg;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q <= roll_ang;
      yaw_q  <= yaw_ang;
      flag_q <= sat_q[CORDIC_LAT-1].sat_pos || sat_q[CORDIC_LAT-1].sat_neg;
      priority if (sat_q[CORDIC_LAT-1].sat_pos) begin
        pitch_q <= PITCH_W'(HALF_PI_Q13);
      end else if (sat_q[CORDIC_LAT-1].sat_neg) begin
        pitch_q <= PITCH_W'(-HALF_PI_Q13);
      end else if (pitch_ang > HALF_PI_Q13) begin
        pitch_q <= PITCH_W'(HALF_PI_Q13);
      end else if (pitch_ang < -HALF_PI_Q13) begin
        pitch_q <= PITCH_W'(-HALF_PI_Q13);
      end else begin
        pitch_q <= PITCH_W'(pitch_ang);
      end
    end
  end

  assign m_axis_tvalid = valid_q[PIPE_LEN-1];
  assign m_axis_tdata  = {1'b0, yaw_q, pitch_q, roll_q};
  assign m_axis_tuser  = flag_q;

endmodule

/* sim/euler_checker.sv */
// ----------------------------------------------------------------------------
// euler_checker
// Watches both channels of the quaternion to Euler converter, computes the
// expected roll, pitch, yaw and saturation flag of every accepted quaternion
// and compares them in order with the words leaving the block.
// ----------------------------------------------------------------------------
module euler_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          errors_o,
  output int          pending_o
);
  import qte_pkg::*;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               sat;
  } angles_t;

  angles_t angle_q[$];
  int      err_cnt = 0;

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint root64(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint vector_angle(longint ys, longint xs);
    longint xv, yv, acc, dx, dy;
    xv = xs;
    yv = ys;
    acc = 0;
    if (xs == 0 && ys == 0) return 0;
    if (xs < 0) begin
      xv = -xs;
      yv = -ys;
      acc = (ys >= 0) ? 3294199 : -3294199;
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      dx = floor_shr(yv, i);
      dy = floor_shr(xv, i);
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        acc += longint'(atan_step(i));
      end else begin
        xv -= dx;
        yv += dy;
        acc -= longint'(atan_step(i));
      end
    end
    return clip(floor_shr(acc + 64, 7), 25736);
  endfunction

  function automatic angles_t to_euler(logic [63:0] q);
    longint w, x, y, z, s, one;
    angles_t a;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    one = 64'sd1 << 28;
    a.roll = 16'(vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
    a.yaw  = 16'(vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
    s = 2 * (w * y - z * x);
    a.sat = 1'b0;
    if (s >= one) begin
      a.pitch = 15'(12868);
      a.sat = 1'b1;
    end else if (s <= -one) begin
      a.pitch = -15'sd12868;
      a.sat = 1'b1;
    end else begin
      a.pitch = 15'(clip(vector_angle(s, root64((64'sd1 << 56) - s * s)), 12868));
    end
    return a;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    err_cnt++;
  endtask

  assign errors_o  = err_cnt;
  assign pending_o = angle_q.size();

  always @(posedge clk_i) begin
    angles_t e, g;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) angle_q.push_back(to_euler(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        g.roll  = m_axis_tdata[15:0];
        g.pitch = m_axis_tdata[30:16];
        g.yaw   = m_axis_tdata[46:31];
        g.sat   = m_axis_tuser;
        if (angle_q.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          e = angle_q.pop_front();
          if (g.roll != e.roll) report("roll", g.roll, e.roll);
          if (g.pitch != e.pitch) report("pitch", g.pitch, e.pitch);
          if (g.yaw != e.yaw) report("yaw", g.yaw, e.yaw);
          if (g.sat != e.sat) report("saturation", g.sat, e.sat);
          if (m_axis_tdata[47] !== 1'b0) report("pad", m_axis_tdata[47], 0);
        end
      end
    end
  end
endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives quaternions into the Euler angle converter: directed extremes and
// gimbal-lock cases, then random unit and raw quaternions under several
// idle and stall patterns. The checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          errors, pending, idle_pct, stall_pct;
  int          quiet = 0;
  logic [63:0] quat_q[$];

  always #4 clk_i = ~clk_i;

  quaternion_to_euler uut (.*);

  euler_checker chk (.*, .errors_o(errors), .pending_o(pending));

  function automatic logic [63:0] pack(int w, int x, int y, int z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  function automatic int rcomp();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  function automatic logic [63:0] unit_quat();
    real w, x, y, z, n;
    w = real'(rcomp());
    x = real'(rcomp());
    y = real'(rcomp());
    z = real'(rcomp());
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 1.0) return pack(16384, 0, 0, 0);
    return pack($rtoi(w * 16384.0 / n), $rtoi(x * 16384.0 / n),
                $rtoi(y * 16384.0 / n), $rtoi(z * 16384.0 / n));
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  always @(posedge clk_i) begin
    if (quiet > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int h;
    idle_pct = 0;
    stall_pct = 0;
    quat_q.push_back(pack(16384, 0, 0, 0));
    quat_q.push_back(pack(-16384, 0, 0, 0));
    quat_q.push_back(pack(0, 16384, 0, 0));
    quat_q.push_back(pack(0, 0, 16384, 0));
    quat_q.push_back(pack(0, 0, 0, 16384));
    quat_q.push_back(pack(11585, 0, 11585, 0));
    quat_q.push_back(pack(11585, 0, -11585, 0));
    quat_q.push_back(pack(11586, 0, 11586, 0));
    quat_q.push_back(pack(0, 11585, 0, -11585));
    quat_q.push_back(pack(0, 0, 0, 0));
    quat_q.push_back(pack(-32768, -32768, -32768, -32768));
    quat_q.push_back(pack(32767, 32767, 32767, 32767));
    quat_q.push_back(pack(32767, -32768, 32767, -32768));
    quat_q.push_back(pack(-1, -1, -1, -1));
    quat_q.push_back(pack(0, 16384, 16384, 0));
    quat_q.push_back(pack(8192, 8192, 8192, 8192));
    quat_q.push_back(pack(16384, 16384, 16384, 16384));
    quat_q.push_back(pack(-16384, 16384, -16384, 16384));
    for (int i = 0; i < 540; i++)
      quat_q.push_back(($urandom_range(0, 9) < 7) ? unit_quat() :
                       {$urandom(), $urandom()});
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    h = 0;
    while (quat_q.size() > 0) begin
      if (h % 140 == 0) begin
        case ((h / 140) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 72; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 72; end
          default: begin idle_pct = 33; stall_pct = 33; end
        endcase
      end
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) begin
        void'(quat_q.pop_front());
        h++;
      end
      if (quat_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= quat_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    stall_pct = 0;
    while (pending > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

/* files.f */
hdl/qte_pkg.sv
hdl/qte_sqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler.sv
sim/euler_checker.sv
sim/tb.sv
